/* rtl/bpc_pkg.sv */
package bpc_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_CAL_A = 2'd0;
  localparam logic [1:0] REG_CAL_B = 2'd1;
  localparam logic [1:0] REG_CAL_C = 2'd2;

  // Queue between the front and the back.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // Pipelined divider: numerator and divisor widths, one quotient bit per stage.
  localparam int DIV_NW = 33;
  localparam int DIV_DW = 19;

  localparam logic signed [11:0] TEMP_MIN  = -12'sd2048;
  localparam logic signed [11:0] TEMP_MAX  = 12'sd2047;
  localparam logic [17:0]        PRESS_MAX = 18'h3FFFF;

  typedef struct packed {
    logic signed [15:0] ac1;
    logic signed [15:0] ac2;
    logic signed [15:0] ac3;
    logic        [15:0] ac4;
    logic        [15:0] ac5;
    logic        [15:0] ac6;
    logic signed [15:0] b1;
    logic signed [15:0] b2;
    logic signed [15:0] mc;
    logic signed [15:0] md;
  } cal_t;

  typedef struct packed {
    logic signed [17:0] x1;
    logic        [15:0] up;
  } q_entry_t;

  typedef struct packed {
    logic [QAW:0] count;
    logic         full;
    logic         empty;
  } fifo_stat_t;

endpackage

/* rtl/bpc_front.sv */
module bpc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_raw_temp,
  input  logic [15:0]        in_raw_press,
  input  bpc_pkg::cal_t      cal,
  input  logic               q_full,
  output logic               push,
  output bpc_pkg::q_entry_t  push_data
);

  logic               v_r;
  logic [15:0]        ut_r;
  logic [15:0]        up_r;
  logic signed [16:0] diff;
  logic signed [16:0] ac5_s;
  logic signed [33:0] prod;

  assign in_ready = !v_r || !q_full;
  assign push     = v_r && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      ut_r <= in_raw_temp;
      up_r <= in_raw_press;
    end
  end

  // First temperature term: ((ut - ac6) * ac5) >>> 15.
  always_comb begin
    diff  = $signed({1'b0, ut_r}) - $signed({1'b0, cal.ac6});
    ac5_s = $signed({1'b0, cal.ac5});
    prod  = diff * ac5_s;
    push_data.x1 = prod[32:15];
    push_data.up = up_r;
  end

endmodule

/* rtl/bpc_fifo.sv */
module bpc_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  bpc_pkg::q_entry_t    push_data,
  input  logic                 pop,
  output bpc_pkg::q_entry_t    rd_data,
  output bpc_pkg::fifo_stat_t  stat
);

  bpc_pkg::q_entry_t         mem_r [bpc_pkg::QDEPTH];
  logic [bpc_pkg::QAW-1:0]   wp_r;
  logic [bpc_pkg::QAW-1:0]   rp_r;
  logic [bpc_pkg::QAW:0]     cnt_r;

  assign rd_data    = mem_r[rp_r];
  assign stat.count = cnt_r;
  assign stat.full  = (cnt_r == (bpc_pkg::QAW+1)'(bpc_pkg::QDEPTH));
  assign stat.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

endmodule

/* rtl/bpc_div.sv */
module bpc_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic [bpc_pkg::DIV_NW-1:0]   num_i,
  input  logic [bpc_pkg::DIV_DW-1:0]   den_i,
  output logic [bpc_pkg::DIV_NW-1:0]   quo_o
);

  localparam int NW = bpc_pkg::DIV_NW;
  localparam int DW = bpc_pkg::DIV_DW;

  // Each stage holds the partial remainder, the numerator bits not yet used
  // (shifting out at the top) with quotient bits shifting in at the bottom,
  // and the divisor.
  logic [DW-1:0] rem_r [NW];
  logic [NW-1:0] nq_r  [NW];
  logic [DW-1:0] d_r   [NW];

  logic [DW-1:0] rem_in [NW];
  logic [NW-1:0] nq_in  [NW];
  logic [DW-1:0] d_in   [NW];
  logic [DW:0]   sh     [NW];
  logic          ge     [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign rem_in[k] = '0;
      assign nq_in[k]  = num_i;
      assign d_in[k]   = den_i;
    end else begin : g_rest
      assign rem_in[k] = rem_r[k-1];
      assign nq_in[k]  = nq_r[k-1];
      assign d_in[k]   = d_r[k-1];
    end

    assign sh[k] = {rem_in[k], nq_in[k][NW-1]};
    assign ge[k] = (sh[k] >= {1'b0, d_in[k]});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge[k] ? DW'(sh[k] - {1'b0, d_in[k]}) : sh[k][DW-1:0];
        nq_r[k]  <= {nq_in[k][NW-2:0], ge[k]};
        d_r[k]   <= d_in[k];
      end
    end
  end

  assign quo_o = nq_r[NW-1];

endmodule

/* rtl/bpc_back.sv */
module bpc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  bpc_pkg::cal_t      cal,
  input  logic               q_empty,
  input  bpc_pkg::q_entry_t  q_data,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [11:0] out_temp_tenths,
  output logic [17:0]        out_press_pa,
  output logic               out_div_fault
);

  localparam int NW = bpc_pkg::DIV_NW;
  localparam int DW = bpc_pkg::DIV_DW;

  typedef struct packed {
    logic signed [17:0] x1;
    logic        [15:0] up;
    logic               neg;
    logic               tf;
  } sb1_t;

  typedef struct packed {
    logic signed [11:0] temp;
    logic               fault;
    logic               dbl;
  } sb2_t;

  logic adv;

  // Divider input stage for temperature.
  logic               b0_v_r;
  sb1_t               b0_sb_r;
  logic [NW-1:0]      b0_num_r;
  logic [DW-1:0]      b0_den_r;
  logic signed [18:0] den;
  logic signed [26:0] num_t;
  logic [26:0]        num_mag;
  logic [DW-1:0]      den_mag;

  logic          v1_r  [NW];
  sb1_t          sb1_r [NW];
  logic [NW-1:0] q1;

  // Temperature and pressure coefficient stages.
  logic               t1_v_r, t2_v_r, t3_v_r, t4_v_r, t5_v_r, t6_v_r, t7_v_r;
  logic signed [28:0] t1_b5_r;
  logic [15:0]        t1_up_r, t2_up_r, t3_up_r, t4_up_r;
  logic               t1_tf_r, t2_tf_r, t3_tf_r, t4_tf_r, t5_tf_r, t6_tf_r;
  logic signed [29:0] t2_b6_r;
  logic signed [11:0] t2_temp_r, t3_temp_r, t4_temp_r, t5_temp_r, t6_temp_r;
  logic signed [59:0] t3_b6sq_r;
  logic signed [45:0] t3_ac2b6_r, t3_ac3b6_r;
  logic signed [63:0] t4_b2sq_r, t4_b1sq_r;
  logic signed [34:0] t4_x2a_r;
  logic signed [32:0] t4_x1c_r;
  logic [31:0]        t5_d7_r, t5_tt_r;
  logic [16:0]        t6_b4_r;
  logic [31:0]        t6_b7_r;
  sb2_t               t7_sb_r;
  logic [NW-1:0]      t7_num_r;
  logic [DW-1:0]      t7_den_r;

  logic signed [28:0] x2_t;
  logic signed [25:0] temp_raw;
  logic signed [11:0] temp_sat;
  logic signed [47:0] sq;
  logic signed [63:0] x3a, s3, x3b;
  logic [31:0]        b4_prod, b7_nxt;
  logic               pf;

  logic          v2_r  [NW];
  sb2_t          sb2_r [NW];
  logic [NW-1:0] q2;

  // Pressure correction stages.
  logic               p1_v_r, p2_v_r, p3_v_r;
  logic [33:0]        p1_r, p2_r, p3_r;
  sb2_t               p1_sb_r, p2_sb_r, p3_sb_r;
  logic [51:0]        p2_sqp_r;
  logic [46:0]        p2_m_r;
  logic [63:0]        p3_x1p_r;
  logic signed [31:0] p3_x2p_r;
  logic signed [47:0] negm;
  logic signed [65:0] corr, press_full;
  logic [17:0]        press_sat;

  logic               ov_r;
  logic signed [11:0] o_temp_r;
  logic [17:0]        o_press_r;
  logic               o_fault_r;

  // The whole back pipeline moves together whenever the output register frees.
  assign adv = !ov_r || out_ready;
  assign pop = adv && !q_empty;

  // Temperature divisor x1 + md, numerator mc * 2048, split into sign and size.
  always_comb begin
    den     = 19'(q_data.x1) + 19'(cal.md);
    num_t   = {cal.mc, 11'b0};
    num_mag = num_t[26] ? 27'(-num_t) : num_t;
    den_mag = den[18] ? DW'(-den) : den;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_v_r <= 1'b0;
    end else if (adv) begin
      b0_v_r <= !q_empty;
    end
    if (adv) begin
      b0_sb_r.x1  <= q_data.x1;
      b0_sb_r.up  <= q_data.up;
      b0_sb_r.neg <= cal.mc[15] ^ den[18];
      b0_sb_r.tf  <= (den == '0);
      b0_num_r    <= NW'(num_mag);
      b0_den_r    <= (den == '0) ? DW'(1) : den_mag;
    end
  end

  bpc_div u_div_t (
    .clk   (clk),
    .en    (adv),
    .num_i (b0_num_r),
    .den_i (b0_den_r),
    .quo_o (q1)
  );

  for (genvar k = 0; k < NW; k++) begin : g_line1
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v1_r[k] <= 1'b0;
      end else if (adv) begin
        v1_r[k] <= (k == 0) ? b0_v_r : v1_r[(k == 0) ? 0 : k-1];
      end
      if (adv) begin
        sb1_r[k] <= (k == 0) ? b0_sb_r : sb1_r[(k == 0) ? 0 : k-1];
      end
    end
  end

  always_comb begin
    x2_t     = sb1_r[NW-1].neg ? 29'(-$signed({1'b0, q1[27:0]}))
                               : 29'($signed({1'b0, q1[27:0]}));
    temp_raw = 26'((30'(t1_b5_r) + 30'sd8) >>> 4);
    if (temp_raw < 26'(bpc_pkg::TEMP_MIN)) temp_sat = bpc_pkg::TEMP_MIN;
    else if (temp_raw > 26'(bpc_pkg::TEMP_MAX)) temp_sat = bpc_pkg::TEMP_MAX;
    else temp_sat = temp_raw[11:0];
    sq  = t3_b6sq_r[59:12];
    x3a = (t4_b2sq_r >>> 11) + 64'(t4_x2a_r);
    s3  = (64'(cal.ac1) <<< 2) + x3a + 64'sd2;
    x3b = (64'(t4_x1c_r) + (t4_b1sq_r >>> 16) + 64'sd2) >>> 2;
    b4_prod = {16'b0, cal.ac4} * t5_tt_r;
    b7_nxt  = t5_d7_r * 32'd50000;
    pf      = (t6_b4_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_v_r <= 1'b0;
      t2_v_r <= 1'b0;
      t3_v_r <= 1'b0;
      t4_v_r <= 1'b0;
      t5_v_r <= 1'b0;
      t6_v_r <= 1'b0;
      t7_v_r <= 1'b0;
    end else if (adv) begin
      t1_v_r <= v1_r[NW-1];
      t2_v_r <= t1_v_r;
      t3_v_r <= t2_v_r;
      t4_v_r <= t3_v_r;
      t5_v_r <= t4_v_r;
      t6_v_r <= t5_v_r;
      t7_v_r <= t6_v_r;
    end
    if (adv) begin
      t1_b5_r    <= 29'(sb1_r[NW-1].x1) + x2_t;
      t1_up_r    <= sb1_r[NW-1].up;
      t1_tf_r    <= sb1_r[NW-1].tf;

      t2_b6_r    <= 30'(t1_b5_r) - 30'sd4000;
      t2_temp_r  <= temp_sat;
      t2_up_r    <= t1_up_r;
      t2_tf_r    <= t1_tf_r;

      t3_b6sq_r  <= t2_b6_r * t2_b6_r;
      t3_ac2b6_r <= cal.ac2 * t2_b6_r;
      t3_ac3b6_r <= cal.ac3 * t2_b6_r;
      t3_temp_r  <= t2_temp_r;
      t3_up_r    <= t2_up_r;
      t3_tf_r    <= t2_tf_r;

      t4_b2sq_r  <= cal.b2 * sq;
      t4_b1sq_r  <= cal.b1 * sq;
      t4_x2a_r   <= t3_ac2b6_r[45:11];
      t4_x1c_r   <= t3_ac3b6_r[45:13];
      t4_temp_r  <= t3_temp_r;
      t4_up_r    <= t3_up_r;
      t4_tf_r    <= t3_tf_r;

      // Only the low 32 bits of up - b3 and of x3 + 32768 survive the wrap.
      t5_d7_r    <= {16'b0, t4_up_r} - s3[33:2];
      t5_tt_r    <= x3b[31:0] + 32'd32768;
      t5_temp_r  <= t4_temp_r;
      t5_tf_r    <= t4_tf_r;

      t6_b4_r    <= b4_prod[31:15];
      t6_b7_r    <= b7_nxt;
      t6_temp_r  <= t5_temp_r;
      t6_tf_r    <= t5_tf_r;

      t7_sb_r.temp  <= t6_temp_r;
      t7_sb_r.fault <= t6_tf_r || pf;
      t7_sb_r.dbl   <= t6_b7_r[31];
      t7_num_r      <= t6_b7_r[31] ? {1'b0, t6_b7_r} : {1'b0, t6_b7_r[30:0], 1'b0};
      t7_den_r      <= pf ? DW'(1) : DW'(t6_b4_r);
    end
  end

  bpc_div u_div_p (
    .clk   (clk),
    .en    (adv),
    .num_i (t7_num_r),
    .den_i (t7_den_r),
    .quo_o (q2)
  );

  for (genvar k = 0; k < NW; k++) begin : g_line2
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v2_r[k] <= 1'b0;
      end else if (adv) begin
        v2_r[k] <= (k == 0) ? t7_v_r : v2_r[(k == 0) ? 0 : k-1];
      end
      if (adv) begin
        sb2_r[k] <= (k == 0) ? t7_sb_r : sb2_r[(k == 0) ? 0 : k-1];
      end
    end
  end

  always_comb begin
    negm       = -$signed({1'b0, p2_m_r});
    corr       = $signed({18'b0, p3_x1p_r[63:16]}) + 66'(p3_x2p_r) + 66'sd3791;
    press_full = $signed({32'b0, p3_r}) + (corr >>> 4);
    if (press_full < 66'sd0) press_sat = '0;
    else if (press_full > $signed({48'b0, bpc_pkg::PRESS_MAX})) press_sat = bpc_pkg::PRESS_MAX;
    else press_sat = press_full[17:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
      ov_r   <= 1'b0;
    end else if (adv) begin
      p1_v_r <= v2_r[NW-1];
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
      ov_r   <= p3_v_r;
    end
    if (adv) begin
      p1_r     <= sb2_r[NW-1].dbl ? {q2, 1'b0} : {1'b0, q2};
      p1_sb_r  <= sb2_r[NW-1];

      p2_sqp_r <= 52'(p1_r[33:8]) * 52'(p1_r[33:8]);
      p2_m_r   <= 47'(p1_r) * 47'd7357;
      p2_r     <= p1_r;
      p2_sb_r  <= p1_sb_r;

      p3_x1p_r <= 64'(p2_sqp_r) * 64'd3038;
      p3_x2p_r <= negm[47:16];
      p3_r     <= p2_r;
      p3_sb_r  <= p2_sb_r;

      o_temp_r  <= p3_sb_r.fault ? 12'sd0 : p3_sb_r.temp;
      o_press_r <= p3_sb_r.fault ? 18'd0 : press_sat;
      o_fault_r <= p3_sb_r.fault;
    end
  end

  assign out_valid       = ov_r;
  assign out_temp_tenths = o_temp_r;
  assign out_press_pa    = o_press_r;
  assign out_div_fault   = o_fault_r;

endmodule

/* rtl/baro_temp_pressure_compensation.sv */
// Channel  | Handshake            | Payload
// in       | in_valid / in_ready  | in_raw_temp[15:0], in_raw_press[15:0]
// out      | out_valid / out_ready| out_temp_tenths[11:0], out_press_pa[17:0], out_div_fault
// cfg      | cfg_we               | cfg_index[1:0], cfg_wdata[63:0]
//
// One transaction per cycle is sustained while out_ready stays high; most of the path
// from an accepted transaction to out_valid lies in the two pipelined dividers (33 stages each, one quotient bit
// per stage).
// Synchronous active-low reset clears the calibration words and all valid bits.
// A low out_ready while out_valid is high freezes the whole back pipeline; the input
// register and the four-entry queue still take up to five transactions before in_ready drops.
module baro_temp_pressure_compensation (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_raw_temp,
  input  logic [15:0]        in_raw_press,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [11:0] out_temp_tenths,
  output logic [17:0]        out_press_pa,
  output logic               out_div_fault,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_wdata
);

  logic [63:0] cal_a_r;
  logic [63:0] cal_b_r;
  logic [31:0] cal_c_r;

  bpc_pkg::cal_t       cal;
  bpc_pkg::q_entry_t   q_wdata;
  bpc_pkg::q_entry_t   q_rdata;
  bpc_pkg::fifo_stat_t q_stat;
  logic                q_push;
  logic                q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_a_r <= '0;
      cal_b_r <= '0;
      cal_c_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bpc_pkg::REG_CAL_A: cal_a_r <= cfg_wdata;
        bpc_pkg::REG_CAL_B: cal_b_r <= cfg_wdata;
        bpc_pkg::REG_CAL_C: cal_c_r <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cal.ac1 = cal_a_r[15:0];
    cal.ac2 = cal_a_r[31:16];
    cal.ac3 = cal_a_r[47:32];
    cal.ac4 = cal_a_r[63:48];
    cal.ac5 = cal_b_r[15:0];
    cal.ac6 = cal_b_r[31:16];
    cal.b1  = cal_b_r[47:32];
    cal.b2  = cal_b_r[63:48];
    cal.mc  = cal_c_r[15:0];
    cal.md  = cal_c_r[31:16];
  end

  bpc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_raw_temp  (in_raw_temp),
    .in_raw_press (in_raw_press),
    .cal          (cal),
    .q_full       (q_stat.full),
    .push         (q_push),
    .push_data    (q_wdata)
  );

  bpc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .rd_data   (q_rdata),
    .stat      (q_stat)
  );

  bpc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cal             (cal),
    .q_empty         (q_stat.empty),
    .q_data          (q_rdata),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_temp_tenths (out_temp_tenths),
    .out_press_pa    (out_press_pa),
    .out_div_fault   (out_div_fault)
  );

`ifndef NO_ASSERTIONS
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_fault |-> out_temp_tenths == 12'sd0 && out_press_pa == 18'd0)
    else $error("fault result carries nonzero data");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("queue written while full");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= (bpc_pkg::QAW+1)'(bpc_pkg::QDEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

/* tb/bpc_checker.sv */
module bpc_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [15:0]        in_raw_temp,
  input  logic [15:0]        in_raw_press,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [11:0] out_temp_tenths,
  input  logic [17:0]        out_press_pa,
  input  logic               out_div_fault,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_wdata,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic signed [11:0] temp;
    logic [17:0]        press;
    logic               fault;
  } reading_t;

  logic [63:0] word_a, word_b;
  logic [31:0] word_c;
  reading_t    expected_q[$];

  function automatic longint asr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic reading_t compensate(logic [15:0] ut_raw, logic [15:0] up_raw);
    reading_t r;
    longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    longint ut, up, x1, x2, x3, b3, b5, b6, sq, p, t, pr, den;
    logic [31:0] b4, b7, w;
    ac1 = longint'($signed(word_a[15:0]));
    ac2 = longint'($signed(word_a[31:16]));
    ac3 = longint'($signed(word_a[47:32]));
    ac4 = longint'(word_a[63:48]);
    ac5 = longint'(word_b[15:0]);
    ac6 = longint'(word_b[31:16]);
    b1  = longint'($signed(word_b[47:32]));
    b2  = longint'($signed(word_b[63:48]));
    mc  = longint'($signed(word_c[15:0]));
    md  = longint'($signed(word_c[31:16]));
    ut  = longint'(ut_raw);
    up  = longint'(up_raw);
    r   = '0;
    x1  = asr((ut - ac6) * ac5, 15);
    den = x1 + md;
    if (den == 0) begin
      r.fault = 1'b1;
      return r;
    end
    x2 = (mc * 2048) / den;
    b5 = x1 + x2;
    t  = asr(b5 + 8, 4);
    b6 = b5 - 4000;
    sq = asr(b6 * b6, 12);
    x1 = asr(b2 * sq, 11);
    x2 = asr(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = asr(ac1 * 4 + x3 + 2, 2);
    x1 = asr(ac3 * b6, 13);
    x2 = asr(b1 * sq, 16);
    x3 = asr(x1 + x2 + 2, 2);
    w  = 32'(x3 + 32768);
    b4 = 32'((64'(ac4) * 64'(w)) & 64'hFFFF_FFFF) >> 15;
    if (b4 == 0) begin
      r.fault = 1'b1;
      return r;
    end
    w  = 32'(up - b3);
    b7 = 32'(64'(w) * 64'd50000);
    if (b7 < 32'h8000_0000) p = longint'({b7[30:0], 1'b0} / b4);
    else p = longint'(b7 / b4) * 2;
    x1 = asr(p, 8) * asr(p, 8);
    x1 = asr(x1 * 3038, 16);
    x2 = asr(-7357 * p, 16);
    pr = p + asr(x1 + x2 + 3791, 4);
    if (t < -2048) t = -2048;
    if (t > 2047) t = 2047;
    if (pr < 0) pr = 0;
    if (pr > 262143) pr = 262143;
    r.temp  = 12'(t);
    r.press = 18'(pr);
    return r;
  endfunction

  always @(posedge clk) begin
    reading_t want;
    if (!rst_n) begin
      word_a <= '0;
      word_b <= '0;
      word_c <= '0;
      fail_count <= 0;
      pending <= 0;
      expected_q.delete();
    end else begin
      if (in_valid && in_ready) expected_q.push_back(compensate(in_raw_temp, in_raw_press));
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result transaction t=%0d p=%0d f=%0b",
                                        out_temp_tenths, out_press_pa, out_div_fault);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.temp !== out_temp_tenths || want.press !== out_press_pa ||
              want.fault !== out_div_fault) begin
            if (fail_count < 10)
              $display("mismatch: expected t=%0d p=%0d f=%0b, got t=%0d p=%0d f=%0b",
                       want.temp, want.press, want.fault,
                       out_temp_tenths, out_press_pa, out_div_fault);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_q.size();
      if (cfg_we) begin
        case (cfg_index)
          bpc_pkg::REG_CAL_A: word_a <= cfg_wdata;
          bpc_pkg::REG_CAL_B: word_b <= cfg_wdata;
          bpc_pkg::REG_CAL_C: word_c <= cfg_wdata[31:0];
          default: ;
        endcase
      end
    end
  end
endmodule

/* tb/tb.sv */
module tb;

  // An index past the register list; writes to it are ignored.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [15:0]        in_raw_temp = '0;
  logic [15:0]        in_raw_press = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [11:0] out_temp_tenths;
  logic [17:0]        out_press_pa;
  logic               out_div_fault;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [63:0]        cfg_wdata = '0;
  int                 fail_count, pending;
  int                 cycle = 0;
  int                 send_idle_pct = 0, recv_stall_pct = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  baro_temp_pressure_compensation dut (.*);
  bpc_checker chk (.*);

  always @(posedge clk) begin
    cycle <= cycle + 1;
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (cycle > 3_000_000) begin
      $display("status: fail");
      $finish;
    end
  end

  // Returns at the edge that accepts the transaction, with in_valid still high.
  task automatic send_reading(logic [15:0] ut, logic [15:0] up);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_raw_temp  <= ut;
    in_raw_press <= up;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_cal(logic [1:0] idx, logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Calibration close to a real sensor so that results land in range.
  task automatic load_typical(bit jitter);
    logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic [15:0]        ac4, ac5, ac6;
    ac1 = 16'sd408;  ac2 = -16'sd72;  ac3 = -16'sd14383;
    ac4 = 16'd32741; ac5 = 16'd32757; ac6 = 16'd23153;
    b1  = 16'sd6190; b2  = 16'sd4;    mc  = -16'sd8711; md = 16'sd2868;
    if (jitter) begin
      ac1 += 16'($urandom_range(400)) - 16'sd200;
      ac4 += 16'($urandom_range(2000));
      ac6 += 16'($urandom_range(4000));
      mc  += 16'($urandom_range(2000)) - 16'sd1000;
      b1  += 16'($urandom_range(400)) - 16'sd200;
    end
    write_cal(bpc_pkg::REG_CAL_A, {ac4, ac3, ac2, ac1});
    write_cal(bpc_pkg::REG_CAL_B, {b2, b1, ac6, ac5});
    write_cal(bpc_pkg::REG_CAL_C, {32'h0, md, mc});
  endtask

  task automatic random_burst(int n);
    logic [15:0] ut, up;
    repeat (n) begin
      if ($urandom_range(9) < 7) begin
        ut = 16'(27898 + $urandom_range(8000) - 4000);
        up = 16'(23843 + $urandom_range(16000) - 8000);
      end else begin
        ut = 16'($urandom);
        up = 16'($urandom);
      end
      send_reading(ut, up);
    end
  endtask

  initial begin
    int ph;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // With all coefficients at zero the temperature divisor is zero.
    send_reading(16'h0000, 16'h0000);
    send_reading(16'hFFFF, 16'hFFFF);
    drain();
    load_typical(1'b0);
    send_reading(16'd27898, 16'd23843);
    send_reading(16'h0000, 16'h0000);
    send_reading(16'hFFFF, 16'hFFFF);
    send_reading(16'hFFFF, 16'h0000);
    send_reading(16'h0000, 16'hFFFF);
    send_reading(16'h5555, 16'hAAAA);
    send_reading(16'hAAAA, 16'h5555);
    drain();
    // Temperature divisor zero: ac5 = 0 gives x1 = 0, md = 0.
    write_cal(bpc_pkg::REG_CAL_B, 64'h0004_182E_5A71_0000);
    write_cal(bpc_pkg::REG_CAL_C, 64'h0000_0000_0000_DDF9);
    send_reading(16'd27898, 16'd23843);
    drain();
    // Pressure divisor zero: ac4 = 0.
    load_typical(1'b0);
    write_cal(bpc_pkg::REG_CAL_A, 64'h0000_C7D1_FFB8_0198);
    send_reading(16'd27898, 16'd23843);
    send_reading(16'd1234, 16'd60000);
    drain();
    // Extreme words, all ones and sign bits, to reach saturation.
    write_cal(bpc_pkg::REG_CAL_A, 64'hFFFF_FFFF_FFFF_FFFF);
    write_cal(bpc_pkg::REG_CAL_B, 64'h8000_7FFF_FFFF_FFFF);
    write_cal(bpc_pkg::REG_CAL_C, 64'h0000_0000_0001_7FFF);
    write_cal(REG_UNUSED, 64'hDEAD_BEEF_DEAD_BEEF);
    send_reading(16'h0000, 16'h0000);
    send_reading(16'hFFFF, 16'hFFFF);
    send_reading(16'h8000, 16'h0001);
    drain();
    write_cal(bpc_pkg::REG_CAL_A, 64'h7FFF_8000_8000_8000);
    write_cal(bpc_pkg::REG_CAL_B, 64'h7FFF_8000_0000_0001);
    write_cal(bpc_pkg::REG_CAL_C, 64'h0000_0000_8000_8000);
    send_reading(16'h0000, 16'hFFFF);
    send_reading(16'hFFFF, 16'h0000);
    drain();

    for (ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      if (ph == 6) begin
        write_cal(bpc_pkg::REG_CAL_A, 64'($urandom) << 32 | 64'($urandom));
        write_cal(bpc_pkg::REG_CAL_B, 64'($urandom) << 32 | 64'($urandom));
        write_cal(bpc_pkg::REG_CAL_C, 64'($urandom));
      end else begin
        load_typical(ph != 0);
      end
      random_burst(70);
      // Hold the sender off until the pipeline has emptied, then resume.
      in_valid <= 1'b0;
      @(posedge clk);
      while (pending != 0) @(posedge clk);
      random_burst(80);
      drain();
    end

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
